### rtl/tlv_frame_field_extractor_defines.svh
// assertion helpers shared by the rtl
`ifndef TLV_FRAME_FIELD_EXTRACTOR_DEFINES_SVH
`define TLV_FRAME_FIELD_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TLVFFX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define TLVFFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tlvffx_pkg.sv
package tlvffx_pkg;

  localparam int unsigned POS_W     = 9;
  localparam int unsigned HDR_LEN   = 7;
  localparam int unsigned ENTRY_HDR = 2;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WORD_BYTES = WORD_W / 8;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN     = 3'd2,
    PH_SKIP    = 3'd3,
    PH_CAPTURE = 3'd4,
    PH_DONE    = 3'd5,
    PH_IDLE    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_PAST_END  = 3'd4,
    ST_MALFORMED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAGIC_FIRST  = 2'd0,
    CFG_MAGIC_SECOND = 2'd1,
    CFG_VERSION      = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic       in_body;
    logic       enter_body;
    logic       too_short;
    logic       past_end;
    logic       bad;
    logic [7:0] seq_number;
    logic [7:0] module_number;
    logic [7:0] message_kind;
    logic [7:0] body_length;
  } hdr_info_t;

  typedef struct packed {
    logic              active;
    logic              found;
    logic              malformed;
    logic [7:0]        value_length;
    logic [7:0]        value_offset;
    logic [WORD_W-1:0] value_word;
  } walk_info_t;

  typedef struct packed {
    logic [WORD_W-1:0] value_word;
    logic [7:0]        value_offset;
    logic [7:0]        value_length;
    logic [7:0]        body_length;
    logic [7:0]        message_kind;
    logic [7:0]        module_number;
    logic [7:0]        seq_number;
    status_t           status;
  } result_t;

endpackage

### rtl/tlvffx_header.sv
module tlvffx_header (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic                  first,
  input  logic [7:0]            data_byte,
  input  logic [7:0]            magic_first,
  input  logic [7:0]            magic_second,
  input  logic [7:0]            expected_version,
  output tlvffx_pkg::hdr_info_t info
);

  localparam int unsigned PW = tlvffx_pkg::POS_W;

  logic [PW-1:0] pos_r, pos_nxt, pos_cur;
  logic          bad_r, bad_nxt;
  logic [7:0]    store_r [4];
  logic [7:0]    store_nxt [4];
  logic [1:0]    sidx;

  always_comb begin
    pos_cur   = first ? '0 : pos_r;
    bad_nxt   = first ? 1'b0 : bad_r;
    store_nxt = store_r;
    sidx      = 2'(pos_cur - PW'(3));
    if (pos_cur == PW'(0) && data_byte != magic_first) bad_nxt = 1'b1;
    if (pos_cur == PW'(1) && data_byte != magic_second) bad_nxt = 1'b1;
    if (pos_cur == PW'(2) && data_byte != expected_version) bad_nxt = 1'b1;
    if (pos_cur >= PW'(3) && pos_cur < PW'(tlvffx_pkg::HDR_LEN)) store_nxt[sidx] = data_byte;
    pos_nxt = (&pos_cur) ? pos_cur : pos_cur + PW'(1);
  end

  always_comb begin
    info.in_body       = pos_cur >= PW'(tlvffx_pkg::HDR_LEN);
    info.enter_body    = pos_cur == PW'(tlvffx_pkg::HDR_LEN - 1);
    info.too_short     = pos_cur < PW'(tlvffx_pkg::HDR_LEN - 1);
    info.past_end      = (PW'(store_nxt[3]) + PW'(tlvffx_pkg::HDR_LEN - 1)) > pos_cur;
    info.bad           = bad_nxt;
    info.seq_number    = store_nxt[0];
    info.module_number = store_nxt[1];
    info.message_kind  = store_nxt[2];
    info.body_length   = store_nxt[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      bad_r <= 1'b0;
    end else if (go) begin
      pos_r <= pos_nxt;
      bad_r <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      store_r <= store_nxt;
    end
  end

endmodule

### rtl/tlvffx_walker.sv
module tlvffx_walker #(
  parameter int unsigned VALUE_BYTES = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic                   first,
  input  logic                   last,
  input  logic [7:0]             data_byte,
  input  logic [7:0]             query_type,
  input  tlvffx_pkg::hdr_info_t  hdr,
  output tlvffx_pkg::walk_info_t info
);

  localparam int unsigned PW       = tlvffx_pkg::POS_W;
  localparam int unsigned WW       = tlvffx_pkg::WORD_W;
  localparam int unsigned NLANE    = tlvffx_pkg::WORD_BYTES;
  localparam int unsigned CAP      = (VALUE_BYTES < NLANE) ? VALUE_BYTES : NLANE;
  localparam int unsigned CW       = $clog2(CAP + 1);

  tlvffx_pkg::phase_t phase_r, phase_cur, phase_nxt;
  logic          hit_r, hit_cur, hit_nxt;
  logic [7:0]    wanted_r, wanted_cur;
  logic [7:0]    rem_r, rem_cur, rem_nxt;
  logic [PW-1:0] off_r, off_cur, off_nxt;
  logic          found_r, found_cur, found_nxt;
  logic          mal_r, mal_cur, mal_nxt;
  logic [CW-1:0] cnt_r, cnt_cur, cnt_nxt;
  logic [WW-1:0] word_r, word_cur, word_nxt;
  logic [7:0]    mlen_r, mlen_cur, mlen_nxt;
  logic [7:0]    moff_r, moff_cur, moff_nxt;
  logic [PW-1:0] blen9, start;
  logic          active;

  // frame restart view
  always_comb begin
    phase_cur  = first ? tlvffx_pkg::PH_HEADER : phase_r;
    wanted_cur = first ? query_type : wanted_r;
    hit_cur    = first ? 1'b0 : hit_r;
    rem_cur    = first ? '0 : rem_r;
    off_cur    = first ? '0 : off_r;
    found_cur  = first ? 1'b0 : found_r;
    mal_cur    = first ? 1'b0 : mal_r;
    cnt_cur    = first ? '0 : cnt_r;
    word_cur   = first ? '0 : word_r;
    mlen_cur   = first ? '0 : mlen_r;
    moff_cur   = first ? '0 : moff_r;
    active     = first || (phase_r != tlvffx_pkg::PH_IDLE);
  end

  // next state
  always_comb begin
    phase_nxt = phase_cur;
    hit_nxt   = hit_cur;
    rem_nxt   = rem_cur;
    off_nxt   = off_cur;
    found_nxt = found_cur;
    mal_nxt   = mal_cur;
    cnt_nxt   = cnt_cur;
    word_nxt  = word_cur;
    mlen_nxt  = mlen_cur;
    moff_nxt  = moff_cur;
    blen9     = PW'(hdr.body_length);
    start     = off_cur + PW'(1);
    if (hdr.enter_body) phase_nxt = tlvffx_pkg::PH_TYPE;
    if (hdr.in_body && off_cur < blen9) begin
      off_nxt = start;
      unique case (phase_cur)
        tlvffx_pkg::PH_TYPE: begin
          if (off_cur + PW'(tlvffx_pkg::ENTRY_HDR) > blen9) begin
            phase_nxt = tlvffx_pkg::PH_DONE;
          end else begin
            hit_nxt   = data_byte == wanted_cur;
            phase_nxt = tlvffx_pkg::PH_LEN;
          end
        end
        tlvffx_pkg::PH_LEN: begin
          if (start + PW'(data_byte) > blen9) begin
            mal_nxt   = 1'b1;
            phase_nxt = tlvffx_pkg::PH_DONE;
          end else if (hit_cur) begin
            found_nxt = 1'b1;
            mlen_nxt  = data_byte;
            moff_nxt  = start[7:0];
            rem_nxt   = data_byte;
            cnt_nxt   = '0;
            word_nxt  = '0;
            phase_nxt = (data_byte == 8'd0) ? tlvffx_pkg::PH_DONE : tlvffx_pkg::PH_CAPTURE;
          end else begin
            rem_nxt   = data_byte;
            phase_nxt = (data_byte == 8'd0) ? tlvffx_pkg::PH_TYPE : tlvffx_pkg::PH_SKIP;
          end
        end
        tlvffx_pkg::PH_SKIP: begin
          rem_nxt = rem_cur - 8'd1;
          if (rem_nxt == 8'd0) phase_nxt = tlvffx_pkg::PH_TYPE;
        end
        tlvffx_pkg::PH_CAPTURE: begin
          if (cnt_cur < CW'(CAP)) begin
            for (int i = 0; i < NLANE; i++) begin
              if (i < CAP && cnt_cur == CW'(i)) word_nxt[8*i +: 8] = data_byte;
            end
            cnt_nxt = cnt_cur + CW'(1);
          end
          rem_nxt = rem_cur - 8'd1;
          if (rem_nxt == 8'd0) phase_nxt = tlvffx_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end
    if (last) phase_nxt = tlvffx_pkg::PH_IDLE;
  end

  // outputs
  always_comb begin
    info.active       = active;
    info.found        = found_nxt;
    info.malformed    = mal_nxt;
    info.value_length = mlen_nxt;
    info.value_offset = moff_nxt;
    info.value_word   = word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tlvffx_pkg::PH_HEADER;
      wanted_r <= '0;
      hit_r    <= 1'b0;
      rem_r    <= '0;
      off_r    <= '0;
      found_r  <= 1'b0;
      mal_r    <= 1'b0;
      cnt_r    <= '0;
      word_r   <= '0;
      mlen_r   <= '0;
      moff_r   <= '0;
    end else if (go && active) begin
      phase_r  <= phase_nxt;
      wanted_r <= wanted_cur;
      hit_r    <= hit_nxt;
      rem_r    <= rem_nxt;
      off_r    <= off_nxt;
      found_r  <= found_nxt;
      mal_r    <= mal_nxt;
      cnt_r    <= cnt_nxt;
      word_r   <= word_nxt;
      mlen_r   <= mlen_nxt;
      moff_r   <= moff_nxt;
    end
  end

endmodule

### rtl/tlv_frame_field_extractor.sv
// a result is registered when the frame's last byte leaves the input register
// throughput: one byte per cycle, stalling only while a result waits at the output
// the input register and the parse logic feed one result register
// rst_n is synchronous, active low: clears the parser, both pipeline valids and
// the three header check registers
module tlv_frame_field_extractor #(
  parameter int unsigned VALUE_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte, query_type
  input  logic        in_tuser,   // first_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // status, seq_number, module_number, message_kind,
                                  // body_length, value_length, value_offset, value_word
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  `include "tlv_frame_field_extractor_defines.svh"

  localparam int unsigned RW = $bits(tlvffx_pkg::result_t);

  logic [7:0] magic_first_r, magic_second_r, version_r;

  logic       s1_v_r;
  logic [7:0] s1_data_r, s1_query_r;
  logic       s1_first_r, s1_last_r;
  logic       out_free, s1_go, go_act, emit;

  logic                 out_v_r;
  tlvffx_pkg::result_t  res_r, res_nxt;

  tlvffx_pkg::hdr_info_t  hdr;
  tlvffx_pkg::walk_info_t walk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= '0;
      magic_second_r <= '0;
      version_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tlvffx_pkg::CFG_MAGIC_FIRST:  magic_first_r  <= cfg_data;
        tlvffx_pkg::CFG_MAGIC_SECOND: magic_second_r <= cfg_data;
        tlvffx_pkg::CFG_VERSION:      version_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_free  = !out_v_r || out_tready;
  assign s1_go     = s1_v_r && out_free;
  assign in_tready = !s1_v_r || s1_go;
  assign go_act    = s1_go && walk.active;
  assign emit      = go_act && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r  <= in_tdata[7:0];
      s1_query_r <= in_tdata[15:8];
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  tlvffx_header u_header (
    .clk              (clk),
    .rst_n            (rst_n),
    .go               (go_act),
    .first            (s1_first_r),
    .data_byte        (s1_data_r),
    .magic_first      (magic_first_r),
    .magic_second     (magic_second_r),
    .expected_version (version_r),
    .info             (hdr)
  );

  tlvffx_walker #(
    .VALUE_BYTES (VALUE_BYTES)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (s1_go),
    .first      (s1_first_r),
    .last       (s1_last_r),
    .data_byte  (s1_data_r),
    .query_type (s1_query_r),
    .hdr        (hdr),
    .info       (walk)
  );

  // status by priority
  always_comb begin
    res_nxt = '0;
    if (hdr.too_short) begin
      res_nxt.status = tlvffx_pkg::ST_SHORT;
    end else if (hdr.bad) begin
      res_nxt.status = tlvffx_pkg::ST_BAD_HDR;
    end else begin
      res_nxt.seq_number    = hdr.seq_number;
      res_nxt.module_number = hdr.module_number;
      res_nxt.message_kind  = hdr.message_kind;
      res_nxt.body_length   = hdr.body_length;
      if (hdr.past_end) begin
        res_nxt.status = tlvffx_pkg::ST_PAST_END;
      end else if (walk.found) begin
        res_nxt.status       = tlvffx_pkg::ST_FOUND;
        res_nxt.value_length = walk.value_length;
        res_nxt.value_offset = walk.value_offset;
        res_nxt.value_word   = walk.value_word;
      end else if (walk.malformed) begin
        res_nxt.status = tlvffx_pkg::ST_MALFORMED;
      end else begin
        res_nxt.status = tlvffx_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(88 - RW)'(0), res_r};

  `TLVFFX_ASSERT_SAME(a_status_range, out_tvalid, out_tdata[2:0] <= tlvffx_pkg::ST_MALFORMED, "status code out of range")
  `TLVFFX_ASSERT_SAME(a_value_zero, out_tvalid && out_tdata[2:0] != tlvffx_pkg::ST_FOUND, out_tdata[82:35] == '0, "value fields set without a match")
  `TLVFFX_ASSERT_NEXT(a_emit_source, s1_v_r && !s1_last_r && !(out_v_r && !out_tready), !$rose(out_v_r), "result without last byte")

endmodule
